### rtl/cfp_pkg.sv
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int unsigned IdxW = 9;
  localparam logic [IdxW-1:0] IdxMax = 9'd511;

  localparam logic [IdxW-1:0] PosType = 9'd4;
  localparam logic [IdxW-1:0] PosLen = 9'd5;
  localparam logic [IdxW-1:0] PosPayload = 9'd6;
  localparam logic [IdxW-1:0] PosFooter = 9'd7;
  localparam logic [IdxW-1:0] FrameOverhead = 9'd11;

  localparam logic [7:0] CmdReinit = 8'hA1;
  localparam logic [7:0] CmdStream = 8'hA2;
  localparam logic [7:0] ValOn = 8'h01;
  localparam logic [7:0] ValOff = 8'h02;
  localparam logic [7:0] NewlineByte = 8'h0A;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] command_type;
    logic [7:0] command_value;
    logic       reinit_request;
    logic       stream_enabled;
  } out_t;

  // frame check outcome handed to the command stage
  typedef struct packed {
    logic       frame_valid;
    logic [7:0] command_type;
    logic [7:0] command_value;
  } verdict_t;

  // "FUT0"
  function automatic logic [7:0] head_byte(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0: b = 8'h46;
      2'd1: b = 8'h55;
      2'd2: b = 8'h54;
      2'd3: b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // "END0"
  function automatic logic [7:0] foot_byte(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0: b = 8'h45;
      2'd1: b = 8'h4E;
      2'd2: b = 8'h44;
      2'd3: b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/cfp_frame_track.sv
`timescale 1ns / 1ps

module cfp_frame_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  cfp_pkg::in_t       in_item,
  output cfp_pkg::verdict_t  verdict
);

  logic [cfp_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic [7:0]               len_r, len_nxt;
  logic [7:0]               acc_r, acc_nxt;
  logic                     good_r, good_nxt;
  logic [7:0]               type_r, type_nxt;
  logic [7:0]               value_r, value_nxt;

  logic [cfp_pkg::IdxW-1:0] len_ext;
  logic [cfp_pkg::IdxW-1:0] chk_pos;
  logic [cfp_pkg::IdxW-1:0] end_pos;
  logic [cfp_pkg::IdxW-1:0] foot_off;
  logic [7:0]               b;
  logic [cfp_pkg::IdxW:0]   total;
  logic [cfp_pkg::IdxW:0]   need;

  assign b        = in_item.rx_byte;
  assign len_ext  = {1'b0, len_r};
  assign chk_pos  = cfp_pkg::PosPayload + len_ext;
  assign end_pos  = cfp_pkg::FrameOverhead + len_ext;
  assign foot_off = idx_r - (cfp_pkg::PosFooter + len_ext);

  always_comb begin
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    good_nxt  = good_r;
    type_nxt  = type_r;
    value_nxt = value_r;
    if (idx_r < cfp_pkg::PosType) begin
      if (b != cfp_pkg::head_byte(idx_r[1:0])) good_nxt = 1'b0;
    end else if (idx_r == cfp_pkg::PosType) begin
      type_nxt = b;
      acc_nxt  = acc_r ^ b;
    end else if (idx_r == cfp_pkg::PosLen) begin
      len_nxt = b;
      acc_nxt = acc_r ^ b;
      if (b == 8'd0) good_nxt = 1'b0;
    end else if (idx_r < chk_pos) begin
      if (idx_r == cfp_pkg::PosPayload) value_nxt = b;
      acc_nxt = acc_r ^ b;
    end else if (idx_r == chk_pos) begin
      if (b != acc_r) good_nxt = 1'b0;
    end else if (idx_r < end_pos) begin
      if (b != cfp_pkg::foot_byte(foot_off[1:0])) good_nxt = 1'b0;
    end else if (idx_r == end_pos) begin
      if (b != cfp_pkg::NewlineByte) good_nxt = 1'b0;
    end else begin
      good_nxt = 1'b0;
    end
  end

  assign idx_nxt = (idx_r == cfp_pkg::IdxMax) ? idx_r : idx_r + 9'd1;

  // total length must be exact, with or without the trailing newline
  assign total = {1'b0, idx_r} + 10'd1;
  assign need  = {1'b0, cfp_pkg::FrameOverhead} + {2'b00, len_nxt};

  always_comb begin
    verdict.frame_valid   = good_nxt && ((total == need) || (total == need + 10'd1));
    verdict.command_type  = type_nxt;
    verdict.command_value = value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      len_r   <= '0;
      acc_r   <= '0;
      good_r  <= 1'b1;
      type_r  <= '0;
      value_r <= '0;
    end else if (step_en) begin
      if (in_item.end_of_packet) begin
        idx_r   <= '0;
        len_r   <= '0;
        acc_r   <= '0;
        good_r  <= 1'b1;
        type_r  <= '0;
        value_r <= '0;
      end else begin
        idx_r   <= idx_nxt;
        len_r   <= len_nxt;
        acc_r   <= acc_nxt;
        good_r  <= good_nxt;
        type_r  <= type_nxt;
        value_r <= value_nxt;
      end
    end
  end

endmodule

### rtl/cfp_cmd_apply.sv
`timescale 1ns / 1ps

module cfp_cmd_apply (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               apply_en,
  input  cfp_pkg::verdict_t  verdict,
  output cfp_pkg::out_t      result
);

  logic stream_r, stream_nxt;
  logic reinit;
  logic is_stream;

  assign reinit = verdict.frame_valid && (verdict.command_type == cfp_pkg::CmdReinit)
                  && (verdict.command_value == cfp_pkg::ValOn);
  assign is_stream = verdict.frame_valid && (verdict.command_type == cfp_pkg::CmdStream);

  always_comb begin
    stream_nxt = stream_r;
    if (is_stream) begin
      if (verdict.command_value == cfp_pkg::ValOn) stream_nxt = 1'b1;
      else if (verdict.command_value == cfp_pkg::ValOff) stream_nxt = 1'b0;
    end
  end

  always_comb begin
    result.frame_valid    = verdict.frame_valid;
    result.command_type   = verdict.frame_valid ? verdict.command_type : 8'd0;
    result.command_value  = verdict.frame_valid ? verdict.command_value : 8'd0;
    result.reinit_request = reinit;
    result.stream_enabled = stream_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_r <= 1'b1;
    end else if (apply_en) begin
      stream_r <= stream_nxt;
    end
  end

endmodule

### rtl/command_frame_parser_unit.sv
`timescale 1ns / 1ps

// Command packet deframer. Takes one received byte per cycle while in_ready is high
// (end_of_packet marks the last byte) and checks the frame "FUT0", type, length
// L >= 1, L payload bytes, XOR checksum, "END0" and an optional newline as each
// byte arrives. On the last byte of a packet one result transaction is issued:
// validity, type, first payload byte, a reinit pulse (type A1 value 1) and the
// stream flag after the command (type A2 value 1 enables, 2 disables). Other bytes
// produce no result. Each byte is checked between the input register and the
// result register, and out_valid is registered from that check. The result
// register lets the next byte be taken while a result waits.
module command_frame_parser_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cfp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cfp_pkg::out_t  out_data
);

  logic              in_valid_r;
  cfp_pkg::in_t      in_data_r;
  logic              out_valid_r;
  cfp_pkg::out_t     out_data_r;
  logic              out_free;
  logic              proc_en;
  logic              emit;
  cfp_pkg::verdict_t verdict;
  cfp_pkg::out_t     result;

  assign out_free = !out_valid_r || out_ready;
  // a non-final byte never needs the result register
  assign proc_en  = in_valid_r && (!in_data_r.end_of_packet || out_free);
  assign emit     = proc_en && in_data_r.end_of_packet;
  assign in_ready = !in_valid_r || proc_en;

  cfp_frame_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (proc_en),
    .in_item (in_data_r),
    .verdict (verdict)
  );

  cfp_cmd_apply u_apply (
    .clk      (clk),
    .rst_n    (rst_n),
    .apply_en (emit),
    .verdict  (verdict),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (proc_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/cfp_checker.sv
`timescale 1ns / 1ps

module cfp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cfp_pkg::out_t  out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_valid |->
      out_data.command_type == 8'd0 && out_data.command_value == 8'd0
      && !out_data.reinit_request)
    else $error("rejected frame reports command fields");

  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reinit_request |->
      out_data.frame_valid && out_data.command_type == cfp_pkg::CmdReinit
      && out_data.command_value == cfp_pkg::ValOn)
    else $error("reinit pulse without reinit command");

  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_valid && out_data.command_type == cfp_pkg::CmdStream
    && (out_data.command_value == cfp_pkg::ValOn
        || out_data.command_value == cfp_pkg::ValOff) |->
      out_data.stream_enabled == (out_data.command_value == cfp_pkg::ValOn))
    else $error("stream flag does not follow stream command");

endmodule

bind command_frame_parser_unit cfp_checker u_cfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### dv/command_frame_parser_unit_tb.sv
`timescale 1ns / 1ps

module command_frame_parser_unit_tb;

  localparam int unsigned RandomBytes = 130;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned LongLen = 520;
  localparam int unsigned NumCases = 18;
  localparam logic [31:0] HeadWord = "FUT0";
  localparam logic [31:0] FootWord = "END0";

  typedef enum int {
    FlawNone,
    FlawNewline,
    FlawHeader,
    FlawChecksum,
    FlawFooter,
    FlawZeroLen,
    FlawTrailing,
    FlawBadNewline,
    FlawLong
  } flaw_t;

  typedef struct {
    logic [7:0]    ftype;
    int unsigned   len;
    logic [7:0]    fval;
    flaw_t         flaw;
    int unsigned   cut;
    bit            typed;
    cfp_pkg::out_t want;
  } frame_case_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  cfp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  cfp_pkg::out_t out_data;

  logic quiet;
  logic hold_req;

  cfp_pkg::out_t expected_results[$];
  cfp_pkg::out_t head_result;
  logic [7:0]    pkt_bytes[$];
  frame_case_t   frame_cases[NumCases];
  int unsigned   bytes_sent;
  int unsigned   errors;
  int unsigned   stall_count;

  // deframer shadow state
  logic [8:0] idx_q;
  logic [7:0] plen_q;
  logic [7:0] csum_q;
  logic       good_q;
  logic [7:0] type_q;
  logic [7:0] val_q;
  logic       stream_q;

  command_frame_parser_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void frame_clear();
    idx_q = '0;
    plen_q = '0;
    csum_q = '0;
    good_q = 1'b1;
    type_q = '0;
    val_q = '0;
  endfunction

  // advances the shadow deframer by one byte; returns 1 when a result is due
  function automatic bit deframe_step(input cfp_pkg::in_t d, output cfp_pkg::out_t res);
    int unsigned pos;
    int unsigned len;
    int unsigned total;
    int unsigned need;
    logic [7:0]  b;
    logic        valid;
    logic        reinit;
    b = d.rx_byte;
    pos = idx_q;
    len = plen_q;
    reinit = 1'b0;
    res = '0;
    if (pos < 4) begin
      if (b != HeadWord[31 - 8 * pos -: 8]) good_q = 1'b0;
    end else if (pos == 4) begin
      type_q = b;
      csum_q = csum_q ^ b;
    end else if (pos == 5) begin
      plen_q = b;
      csum_q = csum_q ^ b;
      if (b == 8'd0) good_q = 1'b0;
    end else if (pos < 6 + len) begin
      if (pos == 6) val_q = b;
      csum_q = csum_q ^ b;
    end else if (pos == 6 + len) begin
      if (b != csum_q) good_q = 1'b0;
    end else if (pos < 11 + len) begin
      if (b != FootWord[31 - 8 * ((pos - (7 + len)) & 3) -: 8]) good_q = 1'b0;
    end else if (pos == 11 + len) begin
      if (b != cfp_pkg::NewlineByte) good_q = 1'b0;
    end else begin
      good_q = 1'b0;
    end
    if (idx_q < cfp_pkg::IdxMax) idx_q = idx_q + 1'b1;
    if (!d.end_of_packet) return 1'b0;

    total = pos + 1;
    need = 11 + plen_q;
    valid = good_q && (total == need || total == need + 1);
    if (valid) begin
      if (type_q == cfp_pkg::CmdReinit && val_q == cfp_pkg::ValOn) begin
        reinit = 1'b1;
      end else if (type_q == cfp_pkg::CmdStream) begin
        if (val_q == cfp_pkg::ValOn) stream_q = 1'b1;
        else if (val_q == cfp_pkg::ValOff) stream_q = 1'b0;
      end
    end
    res.frame_valid = valid;
    res.command_type = valid ? type_q : 8'd0;
    res.command_value = valid ? val_q : 8'd0;
    res.reinit_request = reinit;
    res.stream_enabled = stream_q;
    frame_clear();
    return 1'b1;
  endfunction

  task automatic build_frame(input logic [7:0] ftype, input int unsigned len,
                             input logic [7:0] fval, input flaw_t flaw,
                             input int unsigned cut);
    logic [7:0]  b;
    logic [7:0]  sum;
    int unsigned k;
    pkt_bytes.delete();
    for (int i = 0; i < 4; i++) pkt_bytes.push_back(HeadWord[31 - 8 * i -: 8]);
    pkt_bytes.push_back(ftype);
    pkt_bytes.push_back(flaw == FlawZeroLen ? 8'd0 : 8'(len));
    sum = ftype ^ pkt_bytes[5];
    for (int i = 0; i < len; i++) begin
      b = (i == 0) ? fval : 8'($urandom);
      pkt_bytes.push_back(b);
      sum = sum ^ b;
    end
    if (flaw == FlawChecksum) sum = sum ^ 8'($urandom_range(255, 1));
    pkt_bytes.push_back(sum);
    for (int i = 0; i < 4; i++) pkt_bytes.push_back(FootWord[31 - 8 * i -: 8]);
    case (flaw)
      FlawNewline: begin
        pkt_bytes.push_back(cfp_pkg::NewlineByte);
      end
      FlawHeader: begin
        k = $urandom_range(3);
        pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(255, 1));
      end
      FlawFooter: begin
        k = 7 + len + $urandom_range(3);
        pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(255, 1));
      end
      FlawTrailing: begin
        pkt_bytes.push_back(cfp_pkg::NewlineByte);
        pkt_bytes.push_back(8'($urandom));
      end
      FlawBadNewline: begin
        b = 8'($urandom);
        if (b == cfp_pkg::NewlineByte) b = ~b;
        pkt_bytes.push_back(b);
      end
      FlawLong: begin
        while (pkt_bytes.size() < LongLen) pkt_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
    if (cut != 0) begin
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic send_byte(input cfp_pkg::in_t d, input bit typed,
                           input cfp_pkg::out_t want);
    cfp_pkg::out_t res;
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    if (deframe_step(d, res)) expected_results.push_back(typed ? want : res);
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit typed, input cfp_pkg::out_t want);
    cfp_pkg::in_t d;
    foreach (pkt_bytes[i]) begin
      d.rx_byte = pkt_bytes[i];
      d.end_of_packet = (i == pkt_bytes.size() - 1);
      send_byte(d, typed, want);
    end
  endtask

  task automatic send_noise(input int unsigned n);
    pkt_bytes.delete();
    repeat (n) pkt_bytes.push_back(8'($urandom));
    send_packet(1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0]  ftype;
    logic [7:0]  fval;
    int unsigned len;
    int unsigned r;
    int unsigned cut;
    flaw_t       flaw;
    r = $urandom_range(99);
    if (r < 8) begin
      send_noise($urandom_range(16, 1));
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(6, 1);
      case ($urandom_range(4))
        0, 1: ftype = cfp_pkg::CmdReinit;
        2, 3: ftype = cfp_pkg::CmdStream;
        default: ftype = 8'($urandom);
      endcase
      case ($urandom_range(9))
        0, 1, 2: fval = cfp_pkg::ValOn;
        3, 4, 5: fval = cfp_pkg::ValOff;
        default: fval = 8'($urandom);
      endcase
      cut = 0;
      if (r < 32) begin
        flaw = flaw_t'($urandom_range(FlawBadNewline, FlawHeader));
        // short packet variant
        if ($urandom_range(4) == 0) cut = $urandom_range(10 + len, 1);
      end else begin
        flaw = $urandom_range(1) ? FlawNewline : FlawNone;
      end
      build_frame(ftype, len, fval, flaw, cut);
      send_packet(1'b0, '0);
    end
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result channel: random backpressure, plus one long hold on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none actual %p",
                 $realtime, out_data);
        errors++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("frame_valid", head_result.frame_valid, out_data.frame_valid);
        check_field("command_type", head_result.command_type, out_data.command_type);
        check_field("command_value", head_result.command_value, out_data.command_value);
        check_field("reinit_request", head_result.reinit_request,
                    out_data.reinit_request);
        check_field("stream_enabled", head_result.stream_enabled,
                    out_data.stream_enabled);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned pkt_count;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    quiet <= 1'b0;
    hold_req <= 1'b0;
    bytes_sent = 0;
    frame_clear();
    stream_q = 1'b1;

    // type, len, value, flaw, cut, typed, expected
    frame_cases[0] = '{8'h00, 1, 8'h00, FlawNone, 1, 1'b1,
                       '{1'b0, 8'h00, 8'h00, 1'b0, 1'b1}};
    frame_cases[1] = '{cfp_pkg::CmdReinit, 1, cfp_pkg::ValOn, FlawNone, 0, 1'b1,
                       '{1'b1, cfp_pkg::CmdReinit, cfp_pkg::ValOn, 1'b1, 1'b1}};
    frame_cases[2] = '{cfp_pkg::CmdStream, 1, cfp_pkg::ValOff, FlawNewline, 0, 1'b1,
                       '{1'b1, cfp_pkg::CmdStream, cfp_pkg::ValOff, 1'b0, 1'b0}};
    frame_cases[3] = '{cfp_pkg::CmdStream, 3, cfp_pkg::ValOn, FlawNone, 0, 1'b1,
                       '{1'b1, cfp_pkg::CmdStream, cfp_pkg::ValOn, 1'b0, 1'b1}};
    frame_cases[4] = '{cfp_pkg::CmdStream, 2, cfp_pkg::ValOff, FlawNone, 0, 1'b1,
                       '{1'b1, cfp_pkg::CmdStream, cfp_pkg::ValOff, 1'b0, 1'b0}};
    frame_cases[5] = '{cfp_pkg::CmdStream, 1, 8'h03, FlawNone, 0, 1'b1,
                       '{1'b1, cfp_pkg::CmdStream, 8'h03, 1'b0, 1'b0}};
    frame_cases[6] = '{cfp_pkg::CmdReinit, 2, cfp_pkg::ValOff, FlawNewline, 0, 1'b1,
                       '{1'b1, cfp_pkg::CmdReinit, cfp_pkg::ValOff, 1'b0, 1'b0}};
    frame_cases[7] = '{cfp_pkg::CmdReinit, 1, cfp_pkg::ValOn, FlawHeader, 0, 1'b1, '0};
    frame_cases[8] = '{cfp_pkg::CmdStream, 1, cfp_pkg::ValOn, FlawChecksum, 0, 1'b1, '0};
    frame_cases[9] = '{cfp_pkg::CmdStream, 2, cfp_pkg::ValOn, FlawFooter, 0, 1'b1, '0};
    frame_cases[10] = '{cfp_pkg::CmdStream, 1, cfp_pkg::ValOn, FlawZeroLen, 0, 1'b1, '0};
    frame_cases[11] = '{cfp_pkg::CmdStream, 2, cfp_pkg::ValOn, FlawNone, 8, 1'b1, '0};
    frame_cases[12] = '{cfp_pkg::CmdStream, 1, cfp_pkg::ValOn, FlawTrailing, 0, 1'b1, '0};
    frame_cases[13] = '{cfp_pkg::CmdStream, 1, cfp_pkg::ValOn, FlawBadNewline, 0, 1'b1,
                        '0};
    frame_cases[14] = '{cfp_pkg::CmdStream, 1, cfp_pkg::ValOn, FlawLong, 0, 1'b1, '0};
    frame_cases[15] = '{8'hFF, 255, 8'hFF, FlawNone, 0, 1'b1,
                        '{1'b1, 8'hFF, 8'hFF, 1'b0, 1'b0}};
    frame_cases[16] = '{8'h00, 2, 8'h00, FlawNewline, 0, 1'b0, '0};
    frame_cases[17] = '{cfp_pkg::CmdStream, 4, cfp_pkg::ValOn, FlawNone, 0, 1'b0, '0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (frame_cases[i]) begin
      build_frame(frame_cases[i].ftype, frame_cases[i].len, frame_cases[i].fval,
                  frame_cases[i].flaw, frame_cases[i].cut);
      send_packet(frame_cases[i].typed, frame_cases[i].want);
    end

    random_start = bytes_sent;
    pkt_count = 0;
    while (bytes_sent - random_start < RandomBytes) begin
      pkt_count++;
      quiet <= (bytes_sent - random_start >= 40) && (bytes_sent - random_start < 110);
      if (pkt_count == 1) begin
        // results pile up behind a stalled receiver
        hold_req <= 1'b1;
        repeat (12) send_noise(1);
      end
      if (pkt_count == 2) wait_drained();
      send_random_frame();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
